@@ rtl/record_fifo_with_oldest_query_assert.svh @@
// ----------------------------------------------------------------------------
// Record FIFO assertion macros
// Shorthand for the concurrent checks used in the record FIFO.
// ----------------------------------------------------------------------------
`ifndef RECORD_FIFO_WITH_OLDEST_QUERY_ASSERT_SVH
`define RECORD_FIFO_WITH_OLDEST_QUERY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFOQ_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rfoq check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define RFOQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rfoq check failed one cycle later");

`endif

@@ rtl/rfoq_pkg.sv @@
// ----------------------------------------------------------------------------
// Record FIFO package
// Field widths, operation codes and status codes shared by the record FIFO
// and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package rfoq_pkg;

  // Field widths of one request and one result.
  localparam int OP_W     = 3;
  localparam int ID_W     = 32;
  localparam int YEAR_W   = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int REC_W    = ID_W + YEAR_W;

  // Default number of records the queue holds.
  localparam int DEFAULT_QUEUE_DEPTH = 16;

  // Operation codes; codes five to seven do nothing.
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH   = 3'd1;
  localparam logic [OP_W-1:0] OP_POP    = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK   = 3'd3;
  localparam logic [OP_W-1:0] OP_OLDEST = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

@@ rtl/rfoq_in_if.sv @@
// ----------------------------------------------------------------------------
// Record FIFO request channel
// Valid/ready channel carrying one operation and the record to push.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfoq_in_if;

  logic                                valid;
  logic                                ready;
  logic [rfoq_pkg::OP_W-1:0]           op;
  logic signed [rfoq_pkg::ID_W-1:0]    student_id;
  logic [rfoq_pkg::YEAR_W-1:0]         birth_year;

  modport source (output valid, output op, output student_id, output birth_year,
                  input ready);
  modport sink   (input valid, input op, input student_id, input birth_year,
                  output ready);

endinterface

`default_nettype wire

@@ rtl/rfoq_out_if.sv @@
// ----------------------------------------------------------------------------
// Record FIFO result channel
// Valid/ready channel carrying the status, record and fill level of one step.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfoq_out_if;

  logic                                valid;
  logic                                ready;
  logic [rfoq_pkg::STATUS_W-1:0]       status;
  logic signed [rfoq_pkg::ID_W-1:0]    out_id;
  logic [rfoq_pkg::YEAR_W-1:0]         out_year;
  logic [rfoq_pkg::COUNT_W-1:0]        entry_count;
  logic                                is_empty;

  modport source (output valid, output status, output out_id, output out_year,
                  output entry_count, output is_empty, input ready);
  modport sink   (input valid, input status, input out_id, input out_year,
                  input entry_count, input is_empty, output ready);

endinterface

`default_nettype wire

@@ rtl/record_fifo_with_oldest_query.sv @@
// ----------------------------------------------------------------------------
// Record FIFO with oldest-record query
// Bounded FIFO of id/year records held in one synchronous memory, with a
// non-destructive scan that finds the first record with the smallest year.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request: an operation (clear, push, pop, peek, oldest)
//   plus the id and birth year used by a push. out_ch returns exactly one
//   result per request: status, record, records held afterwards, empty flag.
//   Both channels move a request when valid and ready are high together.
// Sequencing:
//   Clear, push and unused codes go from the idle state to the finish state.
//   Pop and peek read the front record from memory and compare it in the scan
//   state. The oldest query scans all N held records, since the single memory
//   read port delivers one record per cycle to the compare.
//   Only one request is in flight at a time.
// Reset:
//   rst_n low empties the queue and drops any pending result. Memory contents
//   are not cleared; only entries written by a push are ever read.
// Stalls:
//   The result register holds while out_ch.ready is low. The next request is
//   still taken and processed; it waits in the finish state until the result
//   register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "record_fifo_with_oldest_query_assert.svh"

module record_fifo_with_oldest_query #(
  parameter int QUEUE_DEPTH = rfoq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire        clk,
  input  wire        rst_n,
  rfoq_in_if.sink    in_ch,
  rfoq_out_if.source out_ch
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W  = rfoq_pkg::ID_W;
  localparam int YR_W  = rfoq_pkg::YEAR_W;
  localparam int REC_W = rfoq_pkg::REC_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // Advance a slot index around the ring.
  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot);
    if (slot == IDX_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end else begin
      return slot + 1'b1;
    end
  endfunction

  // Record memory: one write port, one registered read port.
  logic [REC_W-1:0] rec_mem [QUEUE_DEPTH];
  logic [REC_W-1:0] rd_data_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [REC_W-1:0] wr_data;

  // Control state.
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             first_r, first_nxt;

  // Result being built for the current request.
  logic [rfoq_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ID_W-1:0]               res_id_r, res_id_nxt;
  logic [YR_W-1:0]               res_year_r, res_year_nxt;

  // Output register.
  logic                          out_valid_r, out_valid_nxt;
  logic [rfoq_pkg::STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0]               out_id_r;
  logic [YR_W-1:0]               out_year_r;
  logic [rfoq_pkg::COUNT_W-1:0]  out_count_r;
  logic                          out_empty_r;
  logic                          out_load;

  logic             in_acc;
  logic             is_full;
  logic             is_empty_q;
  logic [ID_W-1:0]  cur_id;
  logic [YR_W-1:0]  cur_year;
  logic             take_cur;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_empty_q  = (count_r == '0);
  assign cur_id      = rd_data_r[REC_W-1:YR_W];
  assign cur_year    = rd_data_r[YR_W-1:0];
  assign take_cur    = first_r || (cur_year < res_year_r);

  // Request sequencing: writes and reads never target the same entry in
  // overlapping cycles, because only one request is in flight at a time.
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    left_nxt       = left_r;
    slot_nxt       = slot_r;
    first_nxt      = first_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_year_nxt   = res_year_r;
    rd_en          = 1'b0;
    rd_addr        = slot_r;
    wr_en          = 1'b0;
    wr_addr        = tail_r;
    wr_data        = {in_ch.student_id, in_ch.birth_year};
    out_load       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_status_nxt = rfoq_pkg::ST_OK;
          res_id_nxt     = '0;
          res_year_nxt   = '0;
          state_nxt      = S_DONE;
          case (in_ch.op)
            rfoq_pkg::OP_CLEAR: begin
              head_nxt  = '0;
              tail_nxt  = '0;
              count_nxt = '0;
            end
            rfoq_pkg::OP_PUSH: begin
              if (is_full) begin
                res_status_nxt = rfoq_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                tail_nxt  = next_slot(tail_r);
                count_nxt = count_r + 1'b1;
              end
            end
            rfoq_pkg::OP_POP, rfoq_pkg::OP_PEEK, rfoq_pkg::OP_OLDEST: begin
              if (is_empty_q) begin
                res_status_nxt = rfoq_pkg::ST_EMPTY;
              end else begin
                // Read the front record; the scan compares the rest.
                rd_en     = 1'b1;
                rd_addr   = head_r;
                slot_nxt  = next_slot(head_r);
                first_nxt = 1'b1;
                state_nxt = S_SCAN;
                if (in_ch.op == rfoq_pkg::OP_OLDEST) begin
                  left_nxt = count_r - 1'b1;
                end else begin
                  left_nxt = '0;
                end
                if (in_ch.op == rfoq_pkg::OP_POP) begin
                  head_nxt  = next_slot(head_r);
                  count_nxt = count_r - 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // Keep the first record with the strictly smallest year.
        if (take_cur) begin
          res_id_nxt   = cur_id;
          res_year_nxt = cur_year;
        end
        first_nxt = 1'b0;
        if (left_r != '0) begin
          rd_en    = 1'b1;
          rd_addr  = slot_r;
          slot_nxt = next_slot(slot_r);
          left_nxt = left_r - 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid follows loads and downstream takes.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      left_r      <= '0;
      slot_r      <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      slot_r      <= slot_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_year_r   <= res_year_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_year_r   <= res_year_r;
      out_count_r  <= rfoq_pkg::COUNT_W'(count_r);
      out_empty_r  <= is_empty_q;
    end
  end

  // Record memory ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= rec_mem[rd_addr];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.out_id      = out_id_r;
  assign out_ch.out_year    = out_year_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.is_empty    = out_empty_r;

  // The fill level never passes the queue depth.
  `RFOQ_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH))
  // An accepted push into a queue with room adds exactly one record.
  `RFOQ_ASSERT_NEXT(a_push_grows, clk, rst_n, in_acc && (in_ch.op == rfoq_pkg::OP_PUSH) && !is_full, count_r == $past(count_r) + 1'b1)
  // An accepted pop of a held record removes one and starts its read.
  `RFOQ_ASSERT_NEXT(a_pop_shrinks, clk, rst_n, in_acc && (in_ch.op == rfoq_pkg::OP_POP) && !is_empty_q, (count_r == $past(count_r) - 1'b1) && (state_r == S_SCAN))

endmodule

`default_nettype wire
